FILE: rtl/ipc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg: shared types and constants of the interrupt priority controller
// Holds the line count, action codes, transaction structs and the types
// that pass between the line cells and the control logic.
// ----------------------------------------------------------------------------
package ipc_pkg;

  localparam int NUM_LINES = 32;
  localparam int IDX_W     = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

  // Priority carried by the empty candidate while no line has been found yet.
  localparam logic [7:0] PRIO_NONE = 8'hFF;

  localparam logic [3:0] ACT_ENABLE     = 4'd0;
  localparam logic [3:0] ACT_DISABLE    = 4'd1;
  localparam logic [3:0] ACT_QUERY_EN   = 4'd2;
  localparam logic [3:0] ACT_SET_PEND   = 4'd3;
  localparam logic [3:0] ACT_CLR_PEND   = 4'd4;
  localparam logic [3:0] ACT_QUERY_PEND = 4'd5;
  localparam logic [3:0] ACT_SET_PRIO   = 4'd6;
  localparam logic [3:0] ACT_GET_PRIO   = 4'd7;
  localparam logic [3:0] ACT_SELECT     = 4'd8;
  localparam logic [3:0] ACT_CLEAR_ALL  = 4'd9;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] irq;
    logic [7:0] new_priority;
  } req_t;

  typedef struct packed {
    logic       status;
    logic       flag;
    logic [7:0] priority_out;
    logic       selected_valid;
    logic [7:0] selected_irq;
  } rsp_t;

  // Best line found so far, handed from cell to cell during a scan.
  typedef struct packed {
    logic       found;
    logic [7:0] prio;
    logic [7:0] line;
  } cand_t;

  // Write command broadcast to all cells; the addressed cell applies the writes, every cell applies clear_all.
  typedef struct packed {
    logic       en_we;
    logic       en_val;
    logic       pend_we;
    logic       pend_val;
    logic       prio_we;
    logic [7:0] prio_val;
    logic       clear_all;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/ipc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_cell: state of one interrupt line
// Holds the enable bit, pending bit and priority of one line, and passes the
// best candidate seen so far on to the next cell every cycle.
// ----------------------------------------------------------------------------
module ipc_cell (
  input  logic               clk,
  input  logic               rst,
  input  ipc_pkg::cell_cmd_t cmd,
  input  logic               sel,
  input  logic [7:0]         line_id,
  input  ipc_pkg::cand_t     cand_in,
  output ipc_pkg::cand_t     cand_out,
  output logic               enable,
  output logic               pending,
  output logic [7:0]         priority_level
);

  logic take;

  // A qualifying line replaces the candidate only when strictly more urgent,
  // so on a tie the earlier (lower numbered) line keeps its place.
  assign take = enable && pending &&
                (!cand_in.found || (priority_level < cand_in.prio));

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      enable         <= 1'b0;
      pending        <= 1'b0;
      priority_level <= '0;
    end else if (sel) begin
      if (cmd.en_we) begin
        enable <= cmd.en_val;
      end
      if (cmd.pend_we) begin
        pending <= cmd.pend_val;
      end
      if (cmd.prio_we) begin
        priority_level <= cmd.prio_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cand_out.found <= 1'b1;
      cand_out.prio  <= priority_level;
      cand_out.line  <= line_id;
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

FILE: rtl/interrupt_priority_controller_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_priority_controller_unit: per-line interrupt state and selection
// Request channel takes one action per transaction; response channel returns
// exactly one result transaction for each request.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (req, req_valid/req_stall) carries an action, a line
//   number and a priority. Every request yields one response transaction on
//   rsp (rsp_valid/rsp_stall), in request order.
//   Per-line actions, clear all and unused codes complete at the accepting
//   edge: the response is valid in the next cycle, and a new request can be
//   accepted every cycle as long as the response register drains.
//   Select next runs a candidate down the row of line cells, one cell per
//   cycle. It occupies the block from acceptance through the scan state and
//   the done state, which waits for the response register; req_stall is high during that time.
//   The response register frees itself when the receiver takes it, so a
//   request is taken in the same cycle the previous response leaves.
//   While the receiver stalls with a response waiting, new requests are held
//   off and a finished scan waits in its final state.
//   Reset (rst, synchronous) clears every enable, pending and priority value
//   and empties the response register.
// ----------------------------------------------------------------------------
module interrupt_priority_controller_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ipc_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ipc_pkg::rsp_t rsp
);

  ipc_pkg::state_t  state;
  ipc_pkg::state_t  state_next;
  logic [ipc_pkg::IDX_W-1:0] cnt;

  logic             out_free;
  logic             idle_ready;
  logic             load_scan;
  logic             accept;
  logic             is_select;
  logic             in_range;
  ipc_pkg::cell_cmd_t cmd;
  ipc_pkg::rsp_t    rsp_single;

  logic [ipc_pkg::NUM_LINES-1:0] sel;
  logic [ipc_pkg::NUM_LINES-1:0] en_vec;
  logic [ipc_pkg::NUM_LINES-1:0] pend_vec;
  logic [7:0]                    prio_vec [ipc_pkg::NUM_LINES];
  ipc_pkg::cand_t                cand [ipc_pkg::NUM_LINES+1];

  logic       sel_en;
  logic       sel_pend;
  logic [7:0] sel_prio;

  // The response register can take a new result when it is empty or when
  // its current transaction leaves in this cycle.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !idle_ready;
  assign accept    = req_valid && idle_ready;
  assign is_select = (req.action == ipc_pkg::ACT_SELECT);
  assign in_range  = (req.irq < 8'(ipc_pkg::NUM_LINES));

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next = state;
    unique case (state)
      ipc_pkg::ST_IDLE: begin
        if (accept && is_select) begin
          state_next = ipc_pkg::ST_SCAN;
        end
      end
      ipc_pkg::ST_SCAN: begin
        if (cnt == ipc_pkg::IDX_W'(ipc_pkg::NUM_LINES - 1)) begin
          state_next = ipc_pkg::ST_DONE;
        end
      end
      ipc_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = ipc_pkg::ST_IDLE;
        end
      end
      default: state_next = ipc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idle_ready = 1'b0;
    load_scan  = 1'b0;
    unique case (state)
      ipc_pkg::ST_IDLE: idle_ready = out_free;
      ipc_pkg::ST_SCAN: ;
      ipc_pkg::ST_DONE: load_scan  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipc_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ipc_pkg::ST_SCAN) begin
        cnt <= cnt + 1'b1;
      end else begin
        cnt <= '0;
      end
    end
  end

  // ------------------------------------------------------- cell write command
  always_comb begin
    cmd = '0;
    cmd.prio_val = req.new_priority;
    if (accept) begin
      unique case (req.action)
        ipc_pkg::ACT_ENABLE: begin
          cmd.en_we  = in_range;
          cmd.en_val = 1'b1;
        end
        ipc_pkg::ACT_DISABLE: begin
          cmd.en_we  = in_range;
          cmd.en_val = 1'b0;
        end
        ipc_pkg::ACT_SET_PEND: begin
          cmd.pend_we  = in_range;
          cmd.pend_val = 1'b1;
        end
        ipc_pkg::ACT_CLR_PEND: begin
          cmd.pend_we  = in_range;
          cmd.pend_val = 1'b0;
        end
        ipc_pkg::ACT_SET_PRIO: cmd.prio_we   = in_range;
        ipc_pkg::ACT_CLEAR_ALL: cmd.clear_all = 1'b1;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------- row of cells
  // Cell 0 starts each cycle with an empty candidate; the last cell's output
  // holds the winner by the time the control reaches the done state.
  assign cand[0] = '{found: 1'b0, prio: ipc_pkg::PRIO_NONE, line: 8'd0};

  for (genvar i = 0; i < ipc_pkg::NUM_LINES; i++) begin : g_line
    assign sel[i] = in_range && (req.irq == 8'(i));

    ipc_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .cmd            (cmd),
      .sel            (sel[i]),
      .line_id        (8'(i)),
      .cand_in        (cand[i]),
      .cand_out       (cand[i+1]),
      .enable         (en_vec[i]),
      .pending        (pend_vec[i]),
      .priority_level (prio_vec[i])
    );
  end

  // Readback of the addressed line; at most one select bit is set.
  always_comb begin
    sel_en   = 1'b0;
    sel_pend = 1'b0;
    sel_prio = '0;
    for (int i = 0; i < ipc_pkg::NUM_LINES; i++) begin
      sel_en   = sel_en   | (sel[i] & en_vec[i]);
      sel_pend = sel_pend | (sel[i] & pend_vec[i]);
      sel_prio = sel_prio | ({8{sel[i]}} & prio_vec[i]);
    end
  end

  // Result of every action other than select next.
  always_comb begin
    rsp_single = '0;
    unique case (req.action)
      ipc_pkg::ACT_ENABLE, ipc_pkg::ACT_DISABLE, ipc_pkg::ACT_SET_PEND,
      ipc_pkg::ACT_CLR_PEND, ipc_pkg::ACT_SET_PRIO: begin
        rsp_single.status = !in_range;
      end
      ipc_pkg::ACT_QUERY_EN: begin
        rsp_single.status = !in_range;
        rsp_single.flag   = sel_en;
      end
      ipc_pkg::ACT_QUERY_PEND: begin
        rsp_single.status = !in_range;
        rsp_single.flag   = sel_pend;
      end
      ipc_pkg::ACT_GET_PRIO: begin
        rsp_single.status       = !in_range;
        rsp_single.priority_out = sel_prio;
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------ response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((accept && !is_select) || load_scan) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_scan) begin
      rsp <= '{status:         1'b0,
               flag:           1'b0,
               priority_out:   8'd0,
               selected_valid: cand[ipc_pkg::NUM_LINES].found,
               selected_irq:   cand[ipc_pkg::NUM_LINES].found ?
                               cand[ipc_pkg::NUM_LINES].line : 8'd0};
    end else if (accept && !is_select) begin
      rsp <= rsp_single;
    end
  end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for interrupt_priority_controller_unit
// Drives actions on the request channel and checks every response against
// a line-state model kept in a scoreboard. A directed opening covers the
// corner cases, then weighted random traffic runs with random gaps on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

  // Action codes the block does not define; they must change nothing.
  localparam logic [3:0] ACT_UNUSED_LO = 4'd10;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

  localparam int RANDOM_ITEMS = 1000;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AT      = 400;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the enable, pending and priority stores, computes the
  // response of every accepted request and checks responses in order.
  // --------------------------------------------------------------------------
  class irq_scoreboard;
    bit            enabled [ipc_pkg::NUM_LINES];
    bit            pending [ipc_pkg::NUM_LINES];
    logic [7:0]    level   [ipc_pkg::NUM_LINES];
    ipc_pkg::rsp_t awaited_rsps[$];
    int            errors;
    int            n_requests;
    int            n_scans;
    int            n_found;
    int            n_bad_line;
    int            n_unused;
    int            n_clears;

    function new();
      clear_lines();
    endfunction

    function void clear_lines();
      for (int i = 0; i < ipc_pkg::NUM_LINES; i++) begin
        enabled[i] = 1'b0;
        pending[i] = 1'b0;
        level[i]   = 8'd0;
      end
    endfunction

    // Applies one action to the mirrored state and returns its response.
    function ipc_pkg::rsp_t resolve_action(ipc_pkg::req_t r);
      ipc_pkg::rsp_t res;
      logic          found;
      logic [7:0]    best_prio;
      int            best_line;
      res = '0;
      if (r.action <= ipc_pkg::ACT_GET_PRIO) begin
        if (r.irq >= ipc_pkg::NUM_LINES) begin
          res.status = 1'b1;
          n_bad_line++;
          return res;
        end
        case (r.action)
          ipc_pkg::ACT_ENABLE:     enabled[r.irq] = 1'b1;
          ipc_pkg::ACT_DISABLE:    enabled[r.irq] = 1'b0;
          ipc_pkg::ACT_QUERY_EN:   res.flag = enabled[r.irq];
          ipc_pkg::ACT_SET_PEND:   pending[r.irq] = 1'b1;
          ipc_pkg::ACT_CLR_PEND:   pending[r.irq] = 1'b0;
          ipc_pkg::ACT_QUERY_PEND: res.flag = pending[r.irq];
          ipc_pkg::ACT_SET_PRIO:   level[r.irq] = r.new_priority;
          default:                 res.priority_out = level[r.irq];
        endcase
      end else if (r.action == ipc_pkg::ACT_SELECT) begin
        found     = 1'b0;
        best_prio = ipc_pkg::PRIO_NONE;
        best_line = 0;
        n_scans++;
        // Strict less-than keeps the lowest line number on a tie.
        for (int i = 0; i < ipc_pkg::NUM_LINES; i++) begin
          if (enabled[i] && pending[i] && (!found || level[i] < best_prio)) begin
            found     = 1'b1;
            best_prio = level[i];
            best_line = i;
          end
        end
        if (found) begin
          res.selected_valid = 1'b1;
          res.selected_irq   = 8'(best_line);
          n_found++;
        end
      end else if (r.action == ipc_pkg::ACT_CLEAR_ALL) begin
        clear_lines();
        n_clears++;
      end else begin
        n_unused++;
      end
      return res;
    endfunction

    function void note_request(ipc_pkg::req_t r);
      n_requests++;
      awaited_rsps.push_back(resolve_action(r));
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    task check_response(ipc_pkg::rsp_t got);
      ipc_pkg::rsp_t want;
      if (awaited_rsps.size() == 0) begin
        report_mismatch("response transaction with no request outstanding");
        return;
      end
      want = awaited_rsps.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %b, wanted %b", got.status, want.status));
      if (got.flag !== want.flag)
        report_mismatch($sformatf("flag %b, wanted %b", got.flag, want.flag));
      if (got.priority_out !== want.priority_out)
        report_mismatch($sformatf("priority_out %h, wanted %h",
                                  got.priority_out, want.priority_out));
      if (got.selected_valid !== want.selected_valid)
        report_mismatch($sformatf("selected_valid %b, wanted %b",
                                  got.selected_valid, want.selected_valid));
      if (got.selected_irq !== want.selected_irq)
        report_mismatch($sformatf("selected_irq %0d, wanted %0d",
                                  got.selected_irq, want.selected_irq));
    endtask

    function int outstanding();
      return awaited_rsps.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block under test.
  // --------------------------------------------------------------------------
  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  ipc_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  ipc_pkg::rsp_t rsp;

  irq_scoreboard board = new();
  int            rsp_taken = 0;
  bit            held_off  = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  interrupt_priority_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  function automatic ipc_pkg::req_t make_req(logic [3:0] act, logic [7:0] line,
                                             logic [7:0] prio);
    ipc_pkg::req_t r;
    r.action       = act;
    r.irq          = line;
    r.new_priority = prio;
    return r;
  endfunction

  // Offers one request transaction after an idle gap and waits until the
  // block accepts it. Inputs only move at the falling edge; the accepting
  // rising edge is where the request is handed to the scoreboard.
  task automatic offer_request(input ipc_pkg::req_t r, input int gap);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       = r;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    board.note_request(r);
    @(negedge clk);
  endtask

  // Draws one random action. Most traffic is well-formed line actions so that
  // enable, pending and priority state builds up between the scans; clear all
  // is kept rare so it does not keep wiping that state.
  function automatic ipc_pkg::req_t random_req();
    int         pick;
    logic [3:0] act;
    logic [7:0] line;
    logic [7:0] prio;
    pick = $urandom_range(0, 99);
    if      (pick < 12) act = ipc_pkg::ACT_ENABLE;
    else if (pick < 18) act = ipc_pkg::ACT_DISABLE;
    else if (pick < 24) act = ipc_pkg::ACT_QUERY_EN;
    else if (pick < 38) act = ipc_pkg::ACT_SET_PEND;
    else if (pick < 44) act = ipc_pkg::ACT_CLR_PEND;
    else if (pick < 50) act = ipc_pkg::ACT_QUERY_PEND;
    else if (pick < 62) act = ipc_pkg::ACT_SET_PRIO;
    else if (pick < 70) act = ipc_pkg::ACT_GET_PRIO;
    else if (pick < 90) act = ipc_pkg::ACT_SELECT;
    else if (pick < 92) act = ipc_pkg::ACT_CLEAR_ALL;
    else                act = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    if ($urandom_range(0, 99) < 92)
      line = 8'($urandom_range(0, ipc_pkg::NUM_LINES - 1));
    else
      line = 8'($urandom_range(ipc_pkg::NUM_LINES, 255));
    // A narrow priority range now and then makes ties between lines common.
    if ($urandom_range(0, 2) == 0)
      prio = 8'($urandom_range(0, 3));
    else
      prio = 8'($urandom);
    return make_req(act, line, prio);
  endfunction

  // --------------------------------------------------------------------------
  // Response monitor: every transaction accepted on the response channel is
  // checked against the oldest outstanding expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0)
      board.check_response(rsp);
  end

  // --------------------------------------------------------------------------
  // Receiver: stalls a random number of cycles before each response, with
  // stretches of no stalling. Once, part way through, it holds off for a
  // long stretch so the response register fills and the block stalls its
  // request channel while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin
    int n;
    @(negedge rst);
    @(negedge clk);
    forever begin
      if (!held_off && rsp_taken >= HOLD_AT) begin
        held_off  = 1'b1;
        rsp_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      n = ((rsp_taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        rsp_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      rsp_stall = 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      rsp_taken++;
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Sender: directed corner cases first, then weighted random traffic.
  // --------------------------------------------------------------------------
  initial begin
    int gap;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Nothing is enabled or pending after reset, so a scan finds no line.
    offer_request(make_req(ipc_pkg::ACT_SELECT, 8'd0, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_QUERY_EN, 8'd0, 8'd0), 1);
    offer_request(make_req(ipc_pkg::ACT_GET_PRIO, 8'd31, 8'd0), 0);
    // Two qualifying lines at equal priority: the lower line number wins.
    offer_request(make_req(ipc_pkg::ACT_ENABLE, 8'd0, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_SET_PEND, 8'd0, 8'd0), 2);
    offer_request(make_req(ipc_pkg::ACT_ENABLE, 8'd31, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_SET_PEND, 8'd31, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_SET_PRIO, 8'd31, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_SELECT, 8'd255, 8'd255), 3);
    // Line 0 at the least urgent priority loses to line 31 at zero.
    offer_request(make_req(ipc_pkg::ACT_SET_PRIO, 8'd0, 8'hFF), 0);
    offer_request(make_req(ipc_pkg::ACT_SELECT, 8'd0, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_GET_PRIO, 8'd0, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_QUERY_PEND, 8'd31, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_CLR_PEND, 8'd31, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_QUERY_PEND, 8'd31, 8'd0), 0);
    // A lone candidate at the least urgent priority must still be found.
    offer_request(make_req(ipc_pkg::ACT_SELECT, 8'd0, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_DISABLE, 8'd0, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_QUERY_EN, 8'd0, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_SELECT, 8'd0, 8'd0), 0);
    // Lines past the end return the out-of-range status and change nothing.
    offer_request(make_req(ipc_pkg::ACT_ENABLE, 8'd32, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_SET_PRIO, 8'd255, 8'h55), 0);
    offer_request(make_req(ipc_pkg::ACT_QUERY_EN, 8'd128, 8'd0), 0);
    // Undefined action codes leave the state alone and answer all zero.
    offer_request(make_req(ACT_UNUSED_LO, 8'd255, 8'd255), 0);
    offer_request(make_req(ACT_UNUSED_HI, 8'd170, 8'd85), 0);
    // Clear all wipes a qualifying line, so the following scan is empty.
    offer_request(make_req(ipc_pkg::ACT_ENABLE, 8'd5, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_SET_PEND, 8'd5, 8'd0), 0);
    offer_request(make_req(ipc_pkg::ACT_CLEAR_ALL, 8'd255, 8'd255), 0);
    offer_request(make_req(ipc_pkg::ACT_SELECT, 8'd5, 8'd0), 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gap = ((i / 64) % 3 == 2) ? 0 : $urandom_range(0, 12);
      offer_request(random_req(), gap);
    end
    req_valid = 1'b0;

    // Drain every outstanding response, then keep the monitor running so that
    // a stray extra response would still be caught.
    while (board.outstanding() != 0) @(posedge clk);
    repeat (ipc_pkg::NUM_LINES + 8) @(posedge clk);

    $display("Covered %0d requests: %0d scans (%0d picked a line), %0d out-of-range lines,",
             board.n_requests, board.n_scans, board.n_found, board.n_bad_line);
    $display("%0d undefined codes, %0d clear-all actions, one %0d-cycle receiver hold-off.",
             board.n_unused, board.n_clears, HOLD_CYCLES);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: even with every action a scan and the longest gaps on both
  // sides, a correct run needs only a small fraction of this time.
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ipc_pkg.sv
rtl/ipc_cell.sv
rtl/interrupt_priority_controller_unit.sv
sim/testbench.sv
